// ----- src/fppid_pkg.sv -----
// Package for the fixed-point PID controller.
// Holds the beat payload types, item kind codes, register indexes and arithmetic constants.
// No dependencies.
package fppid_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int DFILT_SHIFT = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [1:0] {
    KIND_UPDATE  = 2'd0,
    KIND_PRELOAD = 2'd1,
    KIND_RESET   = 2'd2,
    KIND_ALIGN   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_FF_GAIN     = 3'd3,
    REG_DRIVE_MIN   = 3'd4,
    REG_DRIVE_MAX   = 3'd5,
    REG_INTEG_LIMIT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [15:0]  target;
    logic signed [15:0]  sensed;
    logic signed [15:0]  held_drive;
  } pid_in_t;

  typedef struct packed {
    logic signed [15:0]  drive;
    logic                at_high;
    logic                at_low;
  } pid_out_t;

endpackage

// ----- src/fixed_point_pid_controller.sv -----
// Fixed-point Q8 PID controller with anti-windup, feedforward and filtered derivative.
// One input register stage, one combinational update pass, one result register.
// Depends on fppid_pkg.
//
//   Channel  Signals                           Beat
//   input    in_valid, in_ready, in_data       one command (update, preload, reset, align)
//   output   out_valid, out_ready, out_data    one drive value with saturation flags
//   config   cfg_we, cfg_index, cfg_data       one register write, no handshake
//
// An accepted beat is held in the input register, its result in the result register;
// one item is accepted every cycle unless the output stalls. The controller state
// updates as an item moves into the result register, so each item sees all earlier
// ones. A stalled output holds the result register and then the input register.
// Synchronous reset clears both valid flags and the state, and loads config defaults.
module fixed_point_pid_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fppid_pkg::pid_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fppid_pkg::pid_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [fppid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fppid_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fppid_pkg::*;

  localparam logic signed [41:0] DFILT_BIAS = (42'sd1 <<< DFILT_SHIFT) - 42'sd1;
  localparam logic signed [41:0] FRAC_BIAS42 = (42'sd1 <<< FRAC_BITS) - 42'sd1;
  localparam logic signed [35:0] FRAC_BIAS36 = (36'sd1 <<< FRAC_BITS) - 36'sd1;

  function automatic logic signed [31:0] clamp_lim(input logic signed [34:0] v,
                                                   input logic [30:0] lim);
    logic signed [34:0] lim_s;
    lim_s = $signed({4'b0000, lim});
    if (v > lim_s) begin
      return 32'(lim_s);
    end else if (v < -lim_s) begin
      return 32'(-lim_s);
    end
    return 32'(v);
  endfunction

  logic signed [15:0] prop_gain;
  logic signed [15:0] integ_gain;
  logic signed [15:0] deriv_gain;
  logic signed [15:0] ff_gain;
  logic signed [15:0] drive_min;
  logic signed [15:0] drive_max;
  logic [30:0]        integ_limit;

  logic signed [31:0] integ_acc;
  logic signed [15:0] last_sensed;
  logic signed [40:0] deriv_filt;

  pid_in_t  s1;
  logic     s1_valid;
  logic     adv;

  logic signed [31:0] integ_acc_next;
  logic signed [15:0] last_sensed_next;
  logic signed [40:0] deriv_filt_next;
  pid_out_t           res_next;

  logic signed [16:0] err;
  logic signed [16:0] dsens;
  logic signed [32:0] p_term;
  logic signed [32:0] i_prod;
  logic signed [32:0] d_prod;
  logic signed [32:0] ff_term;
  logic signed [31:0] acc_cur;
  logic signed [31:0] ni;
  logic signed [40:0] raw_q8;
  logic signed [41:0] fdiff;
  logic signed [41:0] fdiff_adj;
  logic signed [40:0] filt_upd;
  logic signed [41:0] filt_adj;
  logic signed [32:0] d_q0;
  logic signed [35:0] sum;
  logic signed [35:0] sum_adj;
  logic signed [27:0] q;
  logic signed [34:0] pre_v;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_comb begin
    err     = 17'(s1.target) - 17'(s1.sensed);
    dsens   = 17'(s1.sensed) - 17'(last_sensed);
    p_term  = 33'(prop_gain) * 33'(err);
    i_prod  = 33'(integ_gain) * 33'(err);
    d_prod  = 33'(deriv_gain) * 33'(dsens);
    ff_term = 33'(ff_gain) * 33'(s1.target);

    acc_cur = clamp_lim(35'(integ_acc), integ_limit);
    ni      = clamp_lim(35'(acc_cur) + 35'(i_prod), integ_limit);

    raw_q8    = -(41'(d_prod) <<< FRAC_BITS);
    fdiff     = 42'(raw_q8) - 42'(deriv_filt);
    fdiff_adj = fdiff + (fdiff < 0 ? DFILT_BIAS : 42'sd0);
    filt_upd  = 41'(42'(deriv_filt) + (fdiff_adj >>> DFILT_SHIFT));
    filt_adj  = 42'(filt_upd) + (filt_upd < 0 ? FRAC_BIAS42 : 42'sd0);
    d_q0      = 33'(filt_adj >>> FRAC_BITS);

    sum     = 36'(p_term) + 36'(ni) + 36'(d_q0) + 36'(ff_term);
    sum_adj = sum + (sum < 0 ? FRAC_BIAS36 : 36'sd0);
    q       = 28'(sum_adj >>> FRAC_BITS);

    pre_v = (35'(s1.held_drive) <<< FRAC_BITS) - 35'(p_term) - 35'(ff_term);

    integ_acc_next   = acc_cur;
    last_sensed_next = last_sensed;
    deriv_filt_next  = deriv_filt;
    res_next.drive   = '0;
    res_next.at_high = 1'b0;
    res_next.at_low  = 1'b0;

    unique case (kind_t'(s1.kind))
      KIND_UPDATE: begin
        deriv_filt_next  = filt_upd;
        last_sensed_next = s1.sensed;
        if (q >= 28'(drive_max)) begin
          res_next.drive   = drive_max;
          res_next.at_high = 1'b1;
          if (err <= 0) begin
            integ_acc_next = ni;
          end
        end else if (q <= 28'(drive_min)) begin
          res_next.drive  = drive_min;
          res_next.at_low = 1'b1;
          if (err >= 0) begin
            integ_acc_next = ni;
          end
        end else begin
          res_next.drive = 16'(q);
          integ_acc_next = ni;
        end
      end
      KIND_PRELOAD: begin
        integ_acc_next   = clamp_lim(pre_v, integ_limit);
        last_sensed_next = s1.sensed;
        deriv_filt_next  = '0;
      end
      KIND_RESET: begin
        integ_acc_next   = '0;
        last_sensed_next = '0;
        deriv_filt_next  = '0;
      end
      KIND_ALIGN: begin
        last_sensed_next = s1.sensed;
      end
      default: begin
        integ_acc_next = acc_cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      ff_gain     <= '0;
      drive_min   <= 16'sh8000;
      drive_max   <= 16'sh7FFF;
      integ_limit <= 31'd8388352;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PROP_GAIN:   prop_gain   <= $signed(cfg_data[15:0]);
        REG_INTEG_GAIN:  integ_gain  <= $signed(cfg_data[15:0]);
        REG_DERIV_GAIN:  deriv_gain  <= $signed(cfg_data[15:0]);
        REG_FF_GAIN:     ff_gain     <= $signed(cfg_data[15:0]);
        REG_DRIVE_MIN:   drive_min   <= $signed(cfg_data[15:0]);
        REG_DRIVE_MAX:   drive_max   <= $signed(cfg_data[15:0]);
        REG_INTEG_LIMIT: integ_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      integ_acc   <= '0;
      last_sensed <= '0;
      deriv_filt  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid   <= 1'b1;
        integ_acc   <= integ_acc_next;
        last_sensed <= last_sensed_next;
        deriv_filt  <= deriv_filt_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (!adv && cfg_we && reg_idx_t'(cfg_index) == REG_INTEG_LIMIT) begin
        integ_acc <= clamp_lim(35'(integ_acc), cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= in_data;
    end
    if (adv) begin
      out_data <= res_next;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.at_high && out_data.at_low))
    else $error("both saturation flags set");

  a_high_is_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.at_high) |-> out_data.drive == drive_max)
    else $error("high flag without drive at upper limit");

  a_low_is_min: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.at_low) |-> out_data.drive == drive_min)
    else $error("low flag without drive at lower limit");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid && $stable(s1))
    else $error("input stage lost a beat during output stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input not ready with empty input stage");

endmodule
